>>> hdl/bmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmt_pkg
// shared types, sizes and codes for the bounded multimap table
// ----------------------------------------------------------------------------
package bmt_pkg;

    localparam int KEY_SLOTS      = 16;
    localparam int VALUES_PER_KEY = 8;
    localparam int DATA_WIDTH     = 32;

    localparam int SW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int CW = $clog2(KEY_SLOTS + 1);
    localparam int JW = (VALUES_PER_KEY > 1) ? $clog2(VALUES_PER_KEY) : 1;
    localparam int LW = $clog2(VALUES_PER_KEY + 1);
    localparam int VDEPTH = KEY_SLOTS * VALUES_PER_KEY;
    localparam int AW = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
    localparam int PW = $clog2(VDEPTH + 1);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DISPATCH,
        S_RM_RD,
        S_RM_CMP,
        S_MV_RD,
        S_MV_WR,
        S_RM_FINISH,
        S_LK_RD,
        S_LK_OUT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic    load;
        logic    scan_next;
        logic    hit;
        logic    add_exec;
        logic    j_clr;
        logic    j_inc;
        logic    ram_rd;
        logic    ram_rd_next;
        logic    mv_wr;
        logic    rm_finish;
        logic    out_load;
        logic    out_use_data;
        t_status out_status;
        logic    out_last;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic scan_end;
        logic key_match;
        logic hit;
        logic add_full;
        logic j_at_end;
        logic next_at_end;
        logic val_match;
        logic j_is_last;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hdl/bounded_multimap_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_multimap_table_core
// bounded multimap of keys to value lists with add, remove and lookup
// ----------------------------------------------------------------------------
// One command is worked on at a time. The key slots are scanned one per cycle,
// and the command is then dispatched. Add writes during the dispatch cycle and
// its beat is loaded in the emit state once the output register is free. Remove
// reads the list one value at a time through the single read port of the value
// ram and shifts each later value down with a read and then a write. After the
// scan, lookup reads each value and gives it as a beat, waiting while the
// output register is held. A key that empties is dropped through a row map, so
// no values move. A result, with its pair count, waits in an output register
// while the next command is accepted. Reset empties the table at once.
module bounded_multimap_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_key,
    input  logic [31:0] i_item_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_found_value,
    output logic        o_last,
    output logic [7:0]  o_total_pairs,
    output logic        o_is_empty
);
    import bmt_pkg::*;

    t_dp_cmd  w_ctl;
    t_dp_stat w_stat;

    bmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl)
    );

    bmt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_item_value  (i_item_value),
        .i_ctl         (w_ctl),
        .o_stat        (w_stat),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_last        (o_last),
        .o_total_pairs (o_total_pairs),
        .o_is_empty    (o_is_empty)
    );

endmodule

>>> hdl/bmt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/bmt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmt_datapath
// key slots, list lengths, row map, value ram and result register
// ----------------------------------------------------------------------------
module bmt_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_cmd,
    input  logic [31:0]      i_key,
    input  logic [31:0]      i_item_value,
    input  bmt_pkg::t_dp_cmd i_ctl,
    output bmt_pkg::t_dp_stat o_stat,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_status,
    output logic [31:0]      o_found_value,
    output logic             o_last,
    output logic [7:0]       o_total_pairs,
    output logic             o_is_empty
);
    import bmt_pkg::*;

    logic [DATA_WIDTH-1:0] r_key_store [KEY_SLOTS];
    logic [LW-1:0]         r_len       [KEY_SLOTS];
    logic [SW-1:0]         r_row       [KEY_SLOTS];
    logic [CW-1:0]         r_kiu;
    logic [PW-1:0]         r_total;

    t_op                   r_op;
    logic [DATA_WIDTH-1:0] r_key;
    logic [DATA_WIDTH-1:0] r_val;
    logic [CW-1:0]         r_idx;
    logic                  r_hit;
    logic [SW-1:0]         r_slot;
    logic [LW-1:0]         r_j;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [DATA_WIDTH-1:0] r_out_value;
    logic                  r_out_last;
    logic [PW-1:0]         r_out_total;

    logic [DATA_WIDTH-1:0] w_rdata;
    logic [LW-1:0]         w_len;
    logic [SW-1:0]         w_row;
    logic [SW-1:0]         w_new_slot;
    logic [LW-1:0]         w_j1;
    logic [AW-1:0]         w_raddr;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic                  w_we;
    logic                  w_kiu_full;

    function automatic logic [AW-1:0] f_addr(input logic [SW-1:0] row, input logic [JW-1:0] j);
        f_addr = AW'(row) * AW'(VALUES_PER_KEY) + AW'(j);
    endfunction

    assign w_len      = r_len[r_slot];
    assign w_row      = r_row[r_slot];
    assign w_new_slot = r_kiu[SW-1:0];
    assign w_j1       = r_j + LW'(1);
    assign w_kiu_full = (r_kiu >= CW'(KEY_SLOTS));

    assign w_raddr = i_ctl.ram_rd_next ? f_addr(w_row, w_j1[JW-1:0])
                                       : f_addr(w_row, r_j[JW-1:0]);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = f_addr(w_row, r_j[JW-1:0]);
        w_wdata = w_rdata;
        if (i_ctl.add_exec) begin
            w_we    = 1'b1;
            w_wdata = r_val;
            if (r_hit) begin
                w_waddr = f_addr(w_row, w_len[JW-1:0]);
            end else begin
                w_waddr = f_addr(r_row[w_new_slot], JW'(0));
            end
        end else if (i_ctl.mv_wr) begin
            w_we = 1'b1;
        end
    end

    bmt_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (VDEPTH)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_ctl.ram_rd | i_ctl.ram_rd_next),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // operands and scan state
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op  <= t_op'(i_cmd);
            r_key <= DATA_WIDTH'(i_key);
            r_val <= DATA_WIDTH'(i_item_value);
        end
        if (i_ctl.hit) begin
            r_slot <= r_idx[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_hit <= 1'b0;
            r_j   <= '0;
        end else begin
            if (i_ctl.load) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else if (i_ctl.hit) begin
                r_hit <= 1'b1;
            end else if (i_ctl.scan_next) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_ctl.j_clr) begin
                r_j <= '0;
            end else if (i_ctl.j_inc) begin
                r_j <= w_j1;
            end
        end
    end

    // key slots, shifted down when a key empties
    always_ff @(posedge i_clk) begin
        if (i_ctl.add_exec && !r_hit) begin
            r_key_store[w_new_slot] <= r_key;
        end else if (i_ctl.rm_finish && w_len == LW'(1)) begin
            for (int i = 0; i < KEY_SLOTS - 1; i++) begin
                if (SW'(i) >= r_slot) begin
                    r_key_store[i] <= r_key_store[i + 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_len[i] <= '0;
                r_row[i] <= SW'(i);
            end
            r_kiu   <= '0;
            r_total <= '0;
        end else if (i_ctl.add_exec) begin
            r_total <= r_total + PW'(1);
            if (r_hit) begin
                r_len[r_slot] <= w_len + LW'(1);
            end else begin
                r_len[w_new_slot] <= LW'(1);
                r_kiu             <= r_kiu + CW'(1);
            end
        end else if (i_ctl.rm_finish) begin
            r_total <= r_total - PW'(1);
            if (w_len == LW'(1)) begin
                for (int i = 0; i < KEY_SLOTS - 1; i++) begin
                    if (SW'(i) >= r_slot) begin
                        r_len[i] <= r_len[i + 1];
                        r_row[i] <= r_row[i + 1];
                    end
                end
                r_len[KEY_SLOTS-1] <= '0;
                r_row[KEY_SLOTS-1] <= w_row;
                r_kiu              <= r_kiu - CW'(1);
            end else begin
                r_len[r_slot] <= w_len - LW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_status <= i_ctl.out_status;
            r_out_value  <= i_ctl.out_use_data ? w_rdata : '0;
            r_out_last   <= i_ctl.out_last;
            r_out_total  <= r_total;
        end
    end

    always_comb begin
        o_stat.op          = r_op;
        o_stat.scan_end    = (r_idx >= r_kiu);
        o_stat.key_match   = (r_key_store[r_idx[SW-1:0]] == r_key);
        o_stat.hit         = r_hit;
        o_stat.add_full    = r_hit ? (w_len >= LW'(VALUES_PER_KEY)) : w_kiu_full;
        o_stat.j_at_end    = (r_j >= w_len);
        o_stat.next_at_end = (w_j1 >= w_len);
        o_stat.val_match   = (w_rdata == r_val);
        o_stat.j_is_last   = (w_j1 == w_len);
        o_stat.out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_value = 32'(r_out_value);
    assign o_last        = r_out_last;
    assign o_total_pairs = 8'(r_out_total);
    assign o_is_empty    = (r_out_total == '0);

endmodule

>>> hdl/bmt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmt_ctrl
// command sequencer for scan, add, remove and lookup
// ----------------------------------------------------------------------------
module bmt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bmt_pkg::t_dp_stat i_stat,
    output bmt_pkg::t_dp_cmd  o_ctl
);
    import bmt_pkg::*;

    t_state  r_state, n_state;
    t_status r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_kind           = r_kind;
        o_ctl            = '0;
        o_ctl.out_status = ST_OK;
        o_in_stall       = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = S_DISPATCH;
                end else if (i_stat.key_match) begin
                    o_ctl.hit = 1'b1;
                    n_state   = S_DISPATCH;
                end else begin
                    o_ctl.scan_next = 1'b1;
                end
            end
            S_DISPATCH: begin
                o_ctl.j_clr = 1'b1;
                n_state     = S_EMIT;
                n_kind      = ST_NOT_FOUND;
                unique case (i_stat.op)
                    OP_ADD: begin
                        if (i_stat.add_full) begin
                            n_kind = ST_FULL;
                        end else begin
                            o_ctl.add_exec = 1'b1;
                            n_kind         = ST_OK;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_stat.hit) begin
                            n_state = S_RM_RD;
                        end
                    end
                    OP_LOOKUP: begin
                        if (i_stat.hit) begin
                            n_state = S_LK_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RM_RD: begin
                if (i_stat.j_at_end) begin
                    n_kind  = ST_NOT_FOUND;
                    n_state = S_EMIT;
                end else begin
                    o_ctl.ram_rd = 1'b1;
                    n_state      = S_RM_CMP;
                end
            end
            S_RM_CMP: begin
                if (i_stat.val_match) begin
                    n_state = S_MV_RD;
                end else begin
                    o_ctl.j_inc = 1'b1;
                    n_state     = S_RM_RD;
                end
            end
            S_MV_RD: begin
                if (i_stat.next_at_end) begin
                    n_state = S_RM_FINISH;
                end else begin
                    o_ctl.ram_rd_next = 1'b1;
                    n_state           = S_MV_WR;
                end
            end
            S_MV_WR: begin
                o_ctl.mv_wr = 1'b1;
                o_ctl.j_inc = 1'b1;
                n_state     = S_MV_RD;
            end
            S_RM_FINISH: begin
                o_ctl.rm_finish = 1'b1;
                n_kind          = ST_OK;
                n_state         = S_EMIT;
            end
            S_LK_RD: begin
                if (i_stat.j_at_end) begin
                    n_kind  = ST_NOT_FOUND;
                    n_state = S_EMIT;
                end else begin
                    o_ctl.ram_rd = 1'b1;
                    n_state      = S_LK_OUT;
                end
            end
            S_LK_OUT: begin
                if (i_stat.out_free) begin
                    o_ctl.out_load     = 1'b1;
                    o_ctl.out_use_data = 1'b1;
                    o_ctl.out_status   = ST_OK;
                    o_ctl.out_last     = i_stat.j_is_last;
                    if (i_stat.j_is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.j_inc = 1'b1;
                        n_state     = S_LK_RD;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_ctl.out_load   = 1'b1;
                    o_ctl.out_status = r_kind;
                    o_ctl.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/bmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmt_checker
// port level checks on result beats of the multimap table
// ----------------------------------------------------------------------------
module bmt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [31:0] o_found_value,
    input logic        o_last,
    input logic [7:0]  o_total_pairs,
    input logic        o_is_empty
);
    import bmt_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_found_value)
            && $stable(o_status) && $stable(o_last))
        else $error("stalled result beat changed");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_last && o_found_value == 32'd0)
        else $error("non ok beat not a single zero beat");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_is_empty == (o_total_pairs == 8'd0))
        else $error("empty flag disagrees with pair count");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> !o_is_empty)
        else $error("full reported on empty table");

endmodule

bind bounded_multimap_table_core bmt_checker u_bmt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_found_value (o_found_value),
    .o_last        (o_last),
    .o_total_pairs (o_total_pairs),
    .o_is_empty    (o_is_empty)
);

>>> test/bounded_multimap_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_multimap_table_checker
// watches both channels of the multimap table, keeps its own copy of the
// table, predicts every result beat and compares it field by field
// ----------------------------------------------------------------------------
module bounded_multimap_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_key,
    input  logic [31:0] i_item_value,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_found_value,
    input  logic        i_last,
    input  logic [7:0]  i_total_pairs,
    input  logic        i_is_empty,
    output int          o_errors,
    output int          o_pending,
    output int          o_beats,
    output int          o_full_seen
);
    import bmt_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [31:0] found_value;
        logic        last;
        logic [7:0]  total_pairs;
        logic        is_empty;
    } t_result;

    logic [31:0] keys [KEY_SLOTS];
    logic [31:0] vals [KEY_SLOTS][VALUES_PER_KEY];
    int          lens [KEY_SLOTS];
    int          nkeys;
    int          npairs;
    t_result     expected_beats [$];

    initial begin
        o_errors    = 0;
        o_beats     = 0;
        o_full_seen = 0;
        nkeys       = 0;
        npairs      = 0;
        foreach (lens[i]) lens[i] = 0;
    end

    assign o_pending = expected_beats.size();

    function automatic t_result make_beat(t_status st, logic [31:0] v, logic lst);
        t_result r;
        r.status      = st;
        r.found_value = v;
        r.last        = lst;
        r.total_pairs = npairs[7:0];
        r.is_empty    = (npairs == 0);
        return r;
    endfunction

    function automatic void queue_beat(t_result b);
        expected_beats = {expected_beats, b};
    endfunction

    task automatic apply_command(t_op op, logic [31:0] k, logic [31:0] v);
        int      s;
        int      n;
        t_status st;
        s = -1;
        for (int i = 0; i < nkeys; i++) if (s < 0 && keys[i] == k) s = i;
        case (op)
            OP_ADD: begin
                st = ST_OK;
                if (s >= 0) begin
                    if (lens[s] < VALUES_PER_KEY) begin
                        vals[s][lens[s]] = v;
                        lens[s]++;
                        npairs++;
                    end else begin
                        st = ST_FULL;
                    end
                end else if (nkeys < KEY_SLOTS) begin
                    keys[nkeys]    = k;
                    vals[nkeys][0] = v;
                    lens[nkeys]    = 1;
                    nkeys++;
                    npairs++;
                end else begin
                    st = ST_FULL;
                end
                if (st == ST_FULL) o_full_seen++;
                queue_beat(make_beat(st, 32'd0, 1'b1));
            end
            OP_REMOVE: begin
                st = ST_NOT_FOUND;
                if (s >= 0) begin
                    n = lens[s];
                    for (int j = 0; j < n; j++) begin
                        if (st == ST_NOT_FOUND && vals[s][j] == v) begin
                            for (int i = j; i + 1 < n; i++) vals[s][i] = vals[s][i + 1];
                            lens[s] = n - 1;
                            npairs--;
                            if (n == 1) begin
                                for (int i = s; i + 1 < nkeys; i++) begin
                                    keys[i] = keys[i + 1];
                                    lens[i] = lens[i + 1];
                                    vals[i] = vals[i + 1];
                                end
                                nkeys--;
                                lens[nkeys] = 0;
                            end
                            st = ST_OK;
                        end
                    end
                end
                queue_beat(make_beat(st, 32'd0, 1'b1));
            end
            OP_LOOKUP: begin
                if (s >= 0) begin
                    for (int j = 0; j < lens[s]; j++)
                        queue_beat(make_beat(ST_OK, vals[s][j], j + 1 == lens[s]));
                end else begin
                    queue_beat(make_beat(ST_NOT_FOUND, 32'd0, 1'b1));
                end
            end
            default: queue_beat(make_beat(ST_NOT_FOUND, 32'd0, 1'b1));
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && i_in_valid && !i_in_stall)
            apply_command(t_op'(i_cmd), i_key, i_item_value);
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            o_beats++;
            got = {t_status'(i_status), i_found_value, i_last, i_total_pairs, i_is_empty};
            if (expected_beats.size() == 0) begin
                o_errors++;
                if (o_errors <= 10)
                    $display("unexpected beat: status %0d value %h last %0d total %0d empty %0d",
                             i_status, i_found_value, i_last, i_total_pairs, i_is_empty);
            end else begin
                want = expected_beats.pop_front();
                if (got != want) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("mismatch: exp st %0d val %h last %0d tot %0d emp %0d, %s",
                                 want.status, want.found_value, want.last,
                                 want.total_pairs, want.is_empty,
                                 $sformatf("got st %0d val %h last %0d tot %0d emp %0d",
                                           got.status, got.found_value, got.last,
                                           got.total_pairs, got.is_empty));
                end
            end
        end
    end

endmodule

>>> test/bounded_multimap_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_multimap_table_core_tb
// drives directed and random add, remove and lookup commands into the table
// under varying idle patterns; the checker predicts and compares every beat
// ----------------------------------------------------------------------------
module bounded_multimap_table_core_tb;
    import bmt_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] item_value;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] found_value;
    logic        last;
    logic [7:0]  total_pairs;
    logic        is_empty;
    int          errors;
    int          pending;
    int          beats;
    int          full_seen;
    int          sender_idle;
    int          receiver_idle;
    int          quiet_cycles;
    int          sent;
    logic [31:0] key_pool [8];

    bounded_multimap_table_core i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_cmd        (cmd),
        .i_key        (key),
        .i_item_value (item_value),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_status     (status),
        .o_found_value(found_value),
        .o_last       (last),
        .o_total_pairs(total_pairs),
        .o_is_empty   (is_empty)
    );

    bounded_multimap_table_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_cmd        (cmd),
        .i_key        (key),
        .i_item_value (item_value),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_status     (status),
        .i_found_value(found_value),
        .i_last       (last),
        .i_total_pairs(total_pairs),
        .i_is_empty   (is_empty),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_beats      (beats),
        .o_full_seen  (full_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < receiver_idle);
    end

    // watchdog on accepted beats in either direction
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("bounded_multimap_table_core_tb: errors");
            $finish;
        end
    end

    // valid stays high into the next beat unless the sender idles
    task automatic send_beat(t_op op, logic [31:0] k, logic [31:0] v);
        while ($urandom_range(99) < sender_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        key        <= k;
        item_value <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic random_phase(int count);
        t_op         op;
        logic [31:0] k;
        logic [31:0] v;
        int          r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            op = (r < 45) ? OP_ADD : (r < 75) ? OP_REMOVE : (r < 97) ? OP_LOOKUP : OP_NONE;
            k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(7)];
            v = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(5));
            send_beat(op, k, v);
            if (n == count / 2) drain();
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = OP_ADD;
        key           = '0;
        item_value    = '0;
        out_stall     = 1'b0;
        sender_idle   = 8;
        receiver_idle = 57;
        quiet_cycles  = 0;
        sent          = 0;
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table cases, extremes, list full, key slots full
        send_beat(OP_LOOKUP, 32'h0, 32'h0);
        send_beat(OP_REMOVE, 32'h8000_0000, 32'h0);
        send_beat(OP_NONE, 32'hffff_ffff, 32'hffff_ffff);
        for (int i = 0; i < 9; i++)
            send_beat(OP_ADD, 32'h8000_0000, (i == 0) ? 32'h8000_0000 :
                      (i == 1) ? 32'h7fff_ffff : (i == 2) ? 32'hffff_ffff : 32'(i));
        send_beat(OP_LOOKUP, 32'h8000_0000, 32'h0);
        send_beat(OP_REMOVE, 32'h8000_0000, 32'h7fff_ffff);
        send_beat(OP_REMOVE, 32'h8000_0000, 32'h5555_5555);
        for (int i = 0; i < 16; i++) send_beat(OP_ADD, 32'(i) ^ 32'h7fff_fff0, 32'haaaa_aaaa);
        send_beat(OP_REMOVE, 32'h7fff_fff3, 32'haaaa_aaaa);
        send_beat(OP_LOOKUP, 32'h7fff_fff4, 32'h0);
        drain();

        // empty the table through the remove path
        for (int i = 0; i < 16; i++) send_beat(OP_REMOVE, 32'(i) ^ 32'h7fff_fff0, 32'haaaa_aaaa);
        for (int i = 0; i < 8; i++)
            send_beat(OP_REMOVE, 32'h8000_0000, (i == 0) ? 32'h8000_0000 :
                      (i == 1) ? 32'hffff_ffff : 32'(i + 1));
        send_beat(OP_LOOKUP, 32'h8000_0000, 32'h0);

        random_phase(115);
        sender_idle   = 57;
        receiver_idle = 8;
        random_phase(115);
        sender_idle   = 0;
        receiver_idle = 0;
        random_phase(115);

        drain();
        repeat (200) @(negedge clk);
        $display("%0d commands sent, %0d result beats checked, %0d full drops predicted",
                 sent, beats, full_seen);
        if (errors == 0 && pending == 0) begin
            $display("bounded_multimap_table_core_tb: clean");
        end else begin
            $display("%0d mismatches, %0d beats outstanding", errors, pending);
            $display("bounded_multimap_table_core_tb: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/bmt_pkg.sv
hdl/bmt_ram.sv
hdl/bmt_datapath.sv
hdl/bmt_ctrl.sv
hdl/bounded_multimap_table_core.sv
hdl/bmt_checker.sv
test/bounded_multimap_table_checker.sv
test/bounded_multimap_table_core_tb.sv
